>>> design/rmos_pkg.sv
`default_nettype none

package rmos_pkg;

    // Fixed field geometry
    localparam int VALUE_WIDTH  = 32;
    localparam int NFIELD       = 4;
    localparam int HALF_MAX_DEF = 8;

    // Configuration port geometry
    localparam int HALF_CFG_W = 4;
    localparam int TOL_W      = 20;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_TOL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_TOL   = 2'd2;

    // Register reset values
    localparam logic [HALF_CFG_W-1:0] HALF_RST       = 4'd2;
    localparam logic [TOL_W-1:0]      CENTER_TOL_RST = 20'd20000;
    localparam logic [TOL_W-1:0]      DEPTH_TOL_RST  = 20'd5000;

    typedef logic signed [VALUE_WIDTH-1:0] t_value;

    typedef struct packed {
        logic   in_valid;
        t_value in_floor_center;
        t_value in_floor_depth;
        t_value in_notch_low;
        t_value in_notch_high;
        logic   in_last;
    } t_in_item;

    typedef struct packed {
        logic   out_valid;
        logic   was_filled;
        t_value out_floor_center;
        t_value out_floor_depth;
        t_value out_notch_low;
        t_value out_notch_high;
        logic   last_result;
    } t_out_item;

    typedef struct packed {
        logic [TOL_W-1:0] center_tol;
        logic [TOL_W-1:0] depth_tol;
    } t_tol;

endpackage

`default_nettype wire

>>> design/running_median_outlier_snap.sv
// Flow: an item reaches the back end through a two-entry request queue; each result is formed
//   in states count, scan, drain and finish, the scan comparing one window slot per step up to
//   hi = min(e + h, items seen) <= 2*HALF_MAX; the back end pops a new item only while idle,
//   and a last item flushes up to h + 1 results, each paced by the same window scan.
// Reset (i_rst_n low, synchronous): clears window valid bits, item count, queue, output register
//   and sets half_window 2, center_tolerance 20000, depth_tolerance 5000.
`default_nettype none

module running_median_outlier_snap #(
    parameter int HALF_MAX = rmos_pkg::HALF_MAX_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire rmos_pkg::t_in_item              i_item,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output rmos_pkg::t_out_item                  o_item,
    input  wire logic                            i_cfg_we,
    input  wire logic [rmos_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rmos_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    localparam int HW = $clog2(HALF_MAX+1);
    localparam int PW = $clog2(2*HALF_MAX+1);
    localparam int IW = $bits(rmos_pkg::t_in_item);
    localparam int QW = IW + HW + PW;

    logic [rmos_pkg::HALF_CFG_W-1:0] r_half_window;
    rmos_pkg::t_tol                  r_tol;

    logic                 push;
    logic                 pop;
    logic                 q_full;
    logic                 q_empty;
    logic [HW-1:0]        f_h;
    logic [PW-1:0]        f_kc;
    logic [QW-1:0]        q_wdata;
    logic [QW-1:0]        q_rdata;
    rmos_pkg::t_in_item   q_item;
    logic [HW-1:0]        q_h;
    logic [PW-1:0]        q_kc;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_window    <= rmos_pkg::HALF_RST;
            r_tol.center_tol <= rmos_pkg::CENTER_TOL_RST;
            r_tol.depth_tol  <= rmos_pkg::DEPTH_TOL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rmos_pkg::CFG_HALF_WINDOW:
                    r_half_window <= i_cfg_data[rmos_pkg::HALF_CFG_W-1:0];
                rmos_pkg::CFG_CENTER_TOL:
                    r_tol.center_tol <= i_cfg_data[rmos_pkg::TOL_W-1:0];
                rmos_pkg::CFG_DEPTH_TOL:
                    r_tol.depth_tol <= i_cfg_data[rmos_pkg::TOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    rmos_front #(.HALF_MAX(HALF_MAX)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_item        (i_item),
        .i_half_window (r_half_window),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_h           (f_h),
        .o_kc          (f_kc)
    );

    assign q_wdata = {i_item, f_h, f_kc};

    rmos_queue #(.W(QW), .DEPTH(2)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    assign q_item = q_rdata[QW-1 -: IW];
    assign q_h    = q_rdata[PW +: HW];
    assign q_kc   = q_rdata[PW-1:0];

    rmos_back #(.HALF_MAX(HALF_MAX)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .o_pop     (pop),
        .i_q_item  (q_item),
        .i_q_h     (q_h),
        .i_q_kc    (q_kc),
        .i_tol     (r_tol),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_item    (o_item)
    );

endmodule

`default_nettype wire

>>> design/rmos_front.sv
`default_nettype none

module rmos_front #(
    parameter int HALF_MAX = rmos_pkg::HALF_MAX_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire rmos_pkg::t_in_item              i_item,
    input  wire logic [rmos_pkg::HALF_CFG_W-1:0] i_half_window,
    input  wire logic                            i_q_full,
    output logic                                 o_push,
    output logic [$clog2(HALF_MAX+1)-1:0]        o_h,
    output logic [$clog2(2*HALF_MAX+1)-1:0]      o_kc
);
    localparam int HW   = $clog2(HALF_MAX+1);
    localparam int PW   = $clog2(2*HALF_MAX+1);
    localparam int KMAX = 2*HALF_MAX;

    logic [15:0] r_items_seen;

    // Accept while the queue has room
    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

    // Clamp radius; the window never reaches farther back than 2*HALF_MAX
    assign o_h  = (32'(i_half_window) > HALF_MAX) ? HW'(HALF_MAX) : HW'(i_half_window);
    assign o_kc = (r_items_seen > 16'(KMAX)) ? PW'(KMAX) : PW'(r_items_seen);

    // Count items of the current sequence, saturating
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_items_seen <= '0;
        end else if (o_push) begin
            if (i_item.in_last) begin
                r_items_seen <= '0;
            end else if (r_items_seen != 16'hFFFF) begin
                r_items_seen <= r_items_seen + 16'd1;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/rmos_queue.sv
`default_nettype none

module rmos_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic              o_empty,
    output logic [W-1:0]      o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> design/rmos_back.sv
`default_nettype none

module rmos_back #(
    parameter int HALF_MAX = rmos_pkg::HALF_MAX_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_q_empty,
    output logic                                   o_pop,
    input  wire rmos_pkg::t_in_item                i_q_item,
    input  wire logic [$clog2(HALF_MAX+1)-1:0]     i_q_h,
    input  wire logic [$clog2(2*HALF_MAX+1)-1:0]   i_q_kc,
    input  wire rmos_pkg::t_tol                    i_tol,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output rmos_pkg::t_out_item                    o_item
);
    localparam int DEPTH = 2*HALF_MAX + 1;
    localparam int HW    = $clog2(HALF_MAX+1);
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH+1);
    localparam int VW    = rmos_pkg::VALUE_WIDTH;
    localparam int NF    = rmos_pkg::NFIELD;
    localparam int TW    = rmos_pkg::TOL_W;

    localparam int F_C = 0;
    localparam int F_Z = 1;
    localparam int F_L = 2;
    localparam int F_H = 3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COUNT,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    // Window shift line, newest chunk at position 0
    logic                    r_wv  [DEPTH];
    logic signed [VW-1:0]    r_win [DEPTH][NF];

    t_state                  r_state;
    logic [HW-1:0]           r_h;
    logic [PW-1:0]           r_kc;
    logic                    r_last;
    logic [PW-1:0]           r_e;
    logic [PW-1:0]           r_hi;
    logic [PW-1:0]           r_d;
    logic [CW-1:0]           r_cnt;
    logic [CW-1:0]           r_half;
    logic                    r_own_v;
    logic signed [VW-1:0]    r_own [NF];
    logic                    r_s1_vld;
    logic                    r_s1_ok;
    logic [DEPTH-1:0]        r_s1_lt [NF];
    logic [DEPTH-1:0]        r_s1_le [NF];
    logic signed [VW-1:0]    r_s1_cand [NF];
    logic signed [VW-1:0]    r_med [NF];
    logic                    r_ovalid;
    rmos_pkg::t_out_item     r_out;

    logic [DEPTH-1:0]        c_mask;
    logic [CW-1:0]           c_cnt;
    logic signed [VW-1:0]    c_cand [NF];
    logic [DEPTH-1:0]        c_lt [NF];
    logic [DEPTH-1:0]        c_le [NF];
    logic [NF-1:0]           c_hit;
    logic [PW-1:0]           c_top;
    logic                    c_job;
    logic [PW-1:0]           c_e0;
    logic [VW:0]             c_adc;
    logic [VW:0]             c_adz;
    logic                    c_rep_c;
    logic                    c_rep_z;
    logic                    c_load;
    rmos_pkg::t_out_item     c_res;

    // Window end: min(e + h, items already in sequence)
    function automatic logic [PW-1:0] f_hi(input logic [PW-1:0] e, input logic [HW-1:0] h,
                                           input logic [PW-1:0] kc);
        logic [PW:0] s;
        s = {1'b0, e} + (PW+1)'(h);
        return (s > {1'b0, kc}) ? kc : s[PW-1:0];
    endfunction

    // Absolute difference, exact in one extra bit
    function automatic logic [VW:0] f_absdiff(input logic signed [VW-1:0] a,
                                              input logic signed [VW-1:0] b);
        logic signed [VW:0] d;
        d = {a[VW-1], a} - {b[VW-1], b};
        return d[VW] ? -d : d;
    endfunction

    // Pop a request only while idle
    assign o_pop = (r_state == S_IDLE) && !i_q_empty;

    // Classify the popped request into its first emit job
    assign c_top = (PW'(i_q_h) < i_q_kc) ? PW'(i_q_h) : i_q_kc;
    assign c_job = i_q_item.in_last || (i_q_kc >= PW'(i_q_h));
    assign c_e0  = i_q_item.in_last ? c_top : PW'(i_q_h);

    // Valid entries inside the current window
    always_comb begin
        for (int j = 0; j < DEPTH; j++) begin
            c_mask[j] = r_wv[j] && (PW'(j) <= r_hi);
        end
    end
    assign c_cnt = CW'($countones(c_mask));

    // Compare the candidate against every window entry
    always_comb begin
        for (int f = 0; f < NF; f++) begin
            c_cand[f] = r_win[r_d][f];
            for (int j = 0; j < DEPTH; j++) begin
                c_lt[f][j] = c_mask[j] && (r_win[j][f] < c_cand[f]);
                c_le[f][j] = c_mask[j] && (r_win[j][f] <= c_cand[f]);
            end
        end
    end

    // Candidate is the upper median when it spans sorted index n/2
    always_comb begin
        for (int f = 0; f < NF; f++) begin
            c_hit[f] = r_s1_vld && r_s1_ok
                    && (CW'($countones(r_s1_lt[f])) <= r_half)
                    && (CW'($countones(r_s1_le[f])) > r_half);
        end
    end

    // Form the result of the current job
    assign c_adc   = f_absdiff(r_own[F_C], r_med[F_C]);
    assign c_adz   = f_absdiff(r_own[F_Z], r_med[F_Z]);
    assign c_rep_c = c_adc > {{(VW+1-TW){1'b0}}, i_tol.center_tol};
    assign c_rep_z = c_adz > {{(VW+1-TW){1'b0}}, i_tol.depth_tol};

    always_comb begin
        c_res.out_valid        = r_own_v || (r_cnt != '0);
        c_res.was_filled       = !r_own_v && (r_cnt != '0);
        c_res.out_floor_center = r_own[F_C];
        c_res.out_floor_depth  = r_own[F_Z];
        c_res.out_notch_low    = r_own[F_L];
        c_res.out_notch_high   = r_own[F_H];
        c_res.last_result      = r_last && (r_e == '0);
        if (r_cnt != '0) begin
            if (!r_own_v) begin
                c_res.out_floor_center = r_med[F_C];
                c_res.out_floor_depth  = r_med[F_Z];
                c_res.out_notch_low    = r_med[F_L];
                c_res.out_notch_high   = r_med[F_H];
            end else begin
                if (c_rep_c) c_res.out_floor_center = r_med[F_C];
                if (c_rep_z) c_res.out_floor_depth  = r_med[F_Z];
            end
        end
    end

    assign c_load = (r_state == S_FINISH) && (!r_ovalid || !i_stall);

    // Shift in a new chunk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < DEPTH; j++) r_wv[j] <= 1'b0;
        end else if (o_pop) begin
            r_wv[0] <= i_q_item.in_valid;
            for (int j = 1; j < DEPTH; j++) r_wv[j] <= r_wv[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_win[0][F_C] <= i_q_item.in_floor_center;
            r_win[0][F_Z] <= i_q_item.in_floor_depth;
            r_win[0][F_L] <= i_q_item.in_notch_low;
            r_win[0][F_H] <= i_q_item.in_notch_high;
            for (int j = 1; j < DEPTH; j++) r_win[j] <= r_win[j-1];
        end
    end

    // Compare stage and median capture
    always_ff @(posedge i_clk) begin
        r_s1_ok <= r_wv[r_d];
        for (int f = 0; f < NF; f++) begin
            r_s1_lt[f]   <= c_lt[f];
            r_s1_le[f]   <= c_le[f];
            r_s1_cand[f] <= c_cand[f];
            if (c_hit[f]) r_med[f] <= r_s1_cand[f];
        end
        if (r_state == S_SCAN && r_d == r_e) begin
            r_own_v <= r_wv[r_d];
            for (int f = 0; f < NF; f++) r_own[f] <= c_cand[f];
        end
    end

    // Job sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_s1_vld <= 1'b0;
            r_ovalid <= 1'b0;
            r_h      <= '0;
            r_kc     <= '0;
            r_last   <= 1'b0;
            r_e      <= '0;
            r_hi     <= '0;
            r_d      <= '0;
            r_cnt    <= '0;
            r_half   <= '0;
        end else begin
            r_s1_vld <= (r_state == S_SCAN);
            // Load a finished result, or drop the one just taken
            if (c_load) begin
                r_ovalid <= 1'b1;
                r_out    <= c_res;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_h    <= i_q_h;
                        r_kc   <= i_q_kc;
                        r_last <= i_q_item.in_last;
                        r_e    <= c_e0;
                        r_hi   <= f_hi(c_e0, i_q_h, i_q_kc);
                        if (c_job) r_state <= S_COUNT;
                    end
                end
                S_COUNT: begin
                    r_cnt   <= c_cnt;
                    r_half  <= c_cnt >> 1;
                    r_d     <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_d <= r_d + PW'(1);
                    if (r_d == r_hi) r_state <= S_DRAIN;
                end
                S_DRAIN: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (c_load) begin
                        if (r_last && r_e != '0) begin
                            r_e     <= r_e - PW'(1);
                            r_hi    <= f_hi(r_e - PW'(1), r_h, r_kc);
                            r_state <= S_COUNT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_item  = r_out;

endmodule

`default_nettype wire

>>> design/rmos_checker.sv
`default_nettype none

module rmos_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_valid,
    input wire logic                o_stall,
    input wire logic                o_valid,
    input wire logic                i_stall,
    input wire rmos_pkg::t_out_item o_item
);
    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("result changed while stalled");

    // Fill only ever marks a chunk valid
    a_fill_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.was_filled |-> o_item.out_valid)
        else $error("filled chunk reported invalid");

    // Drop output after reset
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present after reset");

    // Queue is empty after reset, so requests are taken
    a_rst_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall)
        else $error("input stalled after reset");

    // The stall never rises without a request to fill the queue
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_valid) && !$past(o_stall) |-> !o_stall)
        else $error("stall rose without a request");

endmodule

bind running_median_outlier_snap rmos_checker u_rmos_checker (.*);

`default_nettype wire

>>> bench/running_median_outlier_snap_tb.sv
`default_nettype none

module running_median_outlier_snap_tb;
    import rmos_pkg::*;

    localparam int SLOTS = 2 * HALF_MAX_DEF + 1;
    localparam int SETTLE_CYCLES = 80;

    // Predicts the filtered chunk stream and holds results not yet seen
    class median_scoreboard;
        bit          valid_hist[SLOTS];
        longint      field_hist[4][SLOTS];
        int unsigned chunk_count;
        int unsigned wr_slot;
        int unsigned half;
        longint      center_tol;
        longint      depth_tol;
        t_out_item   pending[$];
        int          errors;

        function void clear();
            foreach (valid_hist[i]) valid_hist[i] = 0;
            chunk_count = 0;
            wr_slot     = 0;
            half        = HALF_RST;
            center_tol  = CENTER_TOL_RST;
            depth_tol   = DEPTH_TOL_RST;
            pending.delete();
            errors      = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_HALF_WINDOW: half = data[HALF_CFG_W-1:0];
                CFG_CENTER_TOL:  center_tol = data[TOL_W-1:0];
                CFG_DEPTH_TOL:   depth_tol = data[TOL_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned slot_ago(int unsigned d);
            return (wr_slot + SLOTS - (d % SLOTS)) % SLOTS;
        endfunction

        function longint upper_median(longint vals[$]);
            longint x;
            int     j;
            for (int i = 1; i < vals.size(); i++) begin
                x = vals[i];
                j = i;
                while (j > 0 && vals[j-1] > x) begin
                    vals[j] = vals[j-1];
                    j--;
                end
                vals[j] = x;
            end
            return vals[vals.size() / 2];
        endfunction

        // Filter the chunk e places back from the newest one
        function void filter_chunk(int unsigned e, int unsigned k, int unsigned h, bit is_last);
            longint      win[4][$];
            longint      cur[4];
            longint      med;
            int unsigned reach;
            int unsigned s;
            int unsigned t;
            bit          v;
            bit          filled;
            t_out_item   r;
            reach  = (e + h < k) ? e + h : k;
            s      = slot_ago(e);
            v      = valid_hist[s];
            filled = 0;
            for (int f = 0; f < 4; f++) cur[f] = field_hist[f][s];
            for (int unsigned d = 0; d <= reach; d++) begin
                t = slot_ago(d);
                if (valid_hist[t]) begin
                    for (int f = 0; f < 4; f++) win[f].insert(win[f].size(), field_hist[f][t]);
                end
            end
            if (win[0].size() > 0) begin
                if (!v) begin
                    for (int f = 0; f < 4; f++) cur[f] = upper_median(win[f]);
                    v      = 1;
                    filled = 1;
                end else begin
                    med = upper_median(win[0]);
                    if ((cur[0] > med ? cur[0] - med : med - cur[0]) > center_tol) cur[0] = med;
                    med = upper_median(win[1]);
                    if ((cur[1] > med ? cur[1] - med : med - cur[1]) > depth_tol) cur[1] = med;
                end
            end
            r.out_valid        = v;
            r.was_filled       = filled;
            r.out_floor_center = cur[0][VALUE_WIDTH-1:0];
            r.out_floor_depth  = cur[1][VALUE_WIDTH-1:0];
            r.out_notch_low    = cur[2][VALUE_WIDTH-1:0];
            r.out_notch_high   = cur[3][VALUE_WIDTH-1:0];
            r.last_result      = is_last;
            pending.insert(pending.size(), r);
        endfunction

        function void note_request(t_in_item it);
            int unsigned h;
            int unsigned k;
            int unsigned top;
            h = (half > HALF_MAX_DEF) ? HALF_MAX_DEF : half;
            k = chunk_count;
            valid_hist[wr_slot]    = it.in_valid;
            field_hist[0][wr_slot] = it.in_floor_center;
            field_hist[1][wr_slot] = it.in_floor_depth;
            field_hist[2][wr_slot] = it.in_notch_low;
            field_hist[3][wr_slot] = it.in_notch_high;
            if (!it.in_last) begin
                if (k >= h) filter_chunk(h, k, h, 0);
            end else begin
                top = (h < k) ? h : k;
                for (int e = top; e >= 0; e--) filter_chunk(e, k, h, e == 0);
            end
            wr_slot = (wr_slot + 1) % SLOTS;
            if (it.in_last) chunk_count = 0;
            else if (k < 16'hFFFF) chunk_count = k + 1;
        endfunction

        function void compare(string name, longint exp_v, longint act_v);
            if (exp_v != act_v) begin
                errors++;
                $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(t_out_item act);
            t_out_item exp_r;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none actual %p", $time, act);
                return;
            end
            exp_r = pending.pop_front();
            compare("out_valid", exp_r.out_valid, act.out_valid);
            compare("was_filled", exp_r.was_filled, act.was_filled);
            compare("out_floor_center", exp_r.out_floor_center, act.out_floor_center);
            compare("out_floor_depth", exp_r.out_floor_depth, act.out_floor_depth);
            compare("out_notch_low", exp_r.out_notch_low, act.out_notch_low);
            compare("out_notch_high", exp_r.out_notch_high, act.out_notch_high);
            compare("last_result", exp_r.last_result, act.last_result);
        endfunction
    endclass

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  i_valid = 0;
    logic                  o_stall;
    t_in_item              i_item = '0;
    logic                  o_valid;
    logic                  i_stall = 0;
    t_out_item             o_item;
    logic                  i_cfg_we = 0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = CFG_HALF_WINDOW;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    median_scoreboard sb;
    bit     idling = 1;
    int     stall_left = 0;
    t_value base_val[4];
    int     spread;

    running_median_outlier_snap u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Hold off results in random bursts
    always @(posedge i_clk) begin
        if (!idling) begin
            i_stall <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            i_stall    <= ($urandom_range(0, 3) == 0);
            stall_left <= $urandom_range(1, 16);
        end
    end

    // Check every accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_item);
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic set_regs(int unsigned h, int unsigned ctol, int unsigned dtol);
        write_reg(CFG_HALF_WINDOW, CFG_DATA_W'(h));
        write_reg(CFG_CENTER_TOL, CFG_DATA_W'(ctol));
        write_reg(CFG_DEPTH_TOL, CFG_DATA_W'(dtol));
        i_cfg_we <= 0;
    endtask

    task automatic send_request(t_in_item it);
        if (idling && $urandom_range(0, 3) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_valid <= 1;
        i_item  <= it;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(it);
    endtask

    // Wait out every expected result, then the back end's scan time
    task automatic drain();
        i_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_value near_base(int f);
        t_value v;
        v = base_val[f] + $urandom_range(0, 2 * spread) - spread;
        if ($urandom_range(0, 7) == 0) v = v + $urandom_range(0, 2_000_000) - 1_000_000;
        return v;
    endfunction

    // Clustered chunks with outliers, or raw noise
    function automatic t_in_item make_chunk(bit noise);
        t_in_item it;
        if (noise) begin
            it.in_valid        = 1'($urandom_range(0, 1));
            it.in_floor_center = $urandom;
            it.in_floor_depth  = $urandom;
            it.in_notch_low    = $urandom;
            it.in_notch_high   = $urandom;
        end else begin
            it.in_valid        = ($urandom_range(0, 5) != 0);
            it.in_floor_center = near_base(0);
            it.in_floor_depth  = near_base(1);
            it.in_notch_low    = near_base(2);
            it.in_notch_high   = near_base(3);
        end
        it.in_last = 0;
        return it;
    endfunction

    task automatic send_sequence(int len, bit noise);
        t_in_item it;
        for (int f = 0; f < 4; f++) base_val[f] = $urandom;
        spread = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 30000) : $urandom_range(0, 3000);
        for (int i = 0; i < len; i++) begin
            it = make_chunk(noise);
            it.in_last = (i == len - 1);
            send_request(it);
        end
    endtask

    task automatic send_fields(bit v, t_value c, t_value z, t_value lo, t_value hg, bit last);
        send_request({v, c, z, lo, hg, last});
    endtask

    initial begin
        int sent;
        int len;
        sb = new();
        sb.clear();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: extremes, fill, lone invalid chunk, pass-through, saturated radius
        send_fields(1, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 0);
        send_fields(1, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 0);
        send_fields(0, 32'hFFFFFFFF, 0, 32'hFFFFFFFF, 0, 0);
        send_fields(1, 0, 0, 0, 0, 0);
        send_fields(1, 100, -100, -5, 5, 1);
        send_fields(0, 1, 2, 3, 4, 1);
        send_fields(0, 5, 6, 7, 8, 0);
        send_fields(0, 9, 10, 11, 12, 1);
        drain();
        set_regs(0, 0, 0);
        send_fields(1, 7, 8, 9, 10, 0);
        send_fields(0, -7, -8, -9, -10, 1);
        drain();
        set_regs(15, 1_000_000, 1_000_000);
        send_sequence(12, 0);
        drain();

        // Random settings and sequences
        sent = 22;
        while (sent < 280) begin
            case ($urandom_range(0, 4))
                0: set_regs($urandom_range(0, 15), $urandom_range(0, 1_000_000),
                            $urandom_range(0, 1_000_000));
                1: set_regs(HALF_MAX_DEF, 0, 0);
                2: set_regs(1, 1_000_000, 1_000_000);
                default: set_regs($urandom_range(1, 8), $urandom_range(0, 40000),
                                  $urandom_range(0, 10000));
            endcase
            for (int s = 0; s < 3; s++) begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 24);
                send_sequence(len, $urandom_range(0, 9) == 0);
                sent += len;
            end
            if (sent > 240) idling = 0;
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
design/rmos_pkg.sv
design/rmos_front.sv
design/rmos_queue.sv
design/rmos_back.sv
design/running_median_outlier_snap.sv
design/rmos_checker.sv
bench/running_median_outlier_snap_tb.sv
